// File: design/owjs_pkg.sv
// ----------------------------------------------------------------------------
// owjs_pkg
// Shared types and constants for the ordered window job scheduler.
// ----------------------------------------------------------------------------
package owjs_pkg;

    // Width of the reported count field.
    localparam int COUNT_OUT_W = 7;

    // Per-beat control broadcast from the top level to every cell.
    typedef struct packed {
        logic en;      // input beat accepted this cycle
        logic first;   // clear all finish times before applying the job
        logic active;  // job has nonzero duration
    } t_job_ctl;

endpackage

// File: design/owjs_cell.sv
// ----------------------------------------------------------------------------
// owjs_cell
// One count slot: holds the earliest finish time for its job count and
// tries to append the current job after its lower neighbor's selection.
// ----------------------------------------------------------------------------
module owjs_cell #(
    parameter int TIME_BITS = 32,
    parameter bit IS_HEAD   = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  owjs_pkg::t_job_ctl    i_ctl,
    input  logic [TIME_BITS-1:0]  i_prev_fin,
    input  logic [TIME_BITS-1:0]  i_ws,
    input  logic [TIME_BITS-1:0]  i_we,
    input  logic [TIME_BITS-1:0]  i_dur,
    output logic [TIME_BITS-1:0]  o_fin,
    output logic                  o_grow
);

    localparam int EW = TIME_BITS + 1;

    logic [TIME_BITS-1:0] r_fin;
    logic [TIME_BITS-1:0] n_fin;
    logic [TIME_BITS-1:0] w_prev;
    logic [TIME_BITS-1:0] w_cur;
    logic                 w_prev_ok;
    logic [EW-1:0]        w_p1;
    logic [EW-1:0]        w_start;
    logic [EW-1:0]        w_end;
    logic                 w_take;

    always_comb begin
        // the head cell follows the empty selection, which finishes at time 0
        w_prev    = (IS_HEAD || i_ctl.first) ? '0 : i_prev_fin;
        w_prev_ok = IS_HEAD || (w_prev != '0);
        w_cur     = i_ctl.first ? '0 : r_fin;
        w_p1      = {1'b0, w_prev} + EW'(1);
        w_start   = ({1'b0, i_ws} > w_p1) ? {1'b0, i_ws} : w_p1;
        w_end     = w_start + {1'b0, i_dur} - EW'(1);
        w_take    = i_ctl.active && w_prev_ok && (w_end <= {1'b0, i_we})
                    && ((w_cur == '0) || (w_end < {1'b0, w_cur}));
        n_fin     = w_take ? w_end[TIME_BITS-1:0] : w_cur;
        o_grow    = (n_fin != '0) && (w_cur == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= '0;
        end else if (i_ctl.en) begin
            r_fin <= n_fin;
        end
    end

    assign o_fin = r_fin;

endmodule

// File: design/ordered_window_job_scheduler.sv
// ----------------------------------------------------------------------------
// ordered_window_job_scheduler
// Tracks the largest number of in-order, non-overlapping jobs that fit
// their windows, using a chain of count cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one job per beat:
//   first_job, window_start, window_end (inclusive) and duration.
//   Output channel (o_out_valid / i_out_stall) returns one best_count per job.
//   Every cell updates in the cycle the job beat is accepted; each cell reads
//   its lower neighbor's finish time, so the whole chain applies a job at
//   once. The result is registered, valid in the cycle after its job is
//   accepted; one job is taken per cycle unless the output stalls. The
//   per-cycle path is one cell's add/compare plus an OR over the cells'
//   growth flags feeding the count register. A stalled result holds; a new
//   job is taken while the result register is empty or its beat is taken
//   in the same cycle. Reset (synchronous, active low) clears all finish
//   times, the count and the output valid. first_job clears the table
//   before its job is applied. Time fields are taken modulo 2^TIME_BITS;
//   counts above MAX_JOBS are not kept.
// ----------------------------------------------------------------------------
module ordered_window_job_scheduler #(
    parameter int MAX_JOBS  = 64,
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_first_job,
    input  logic [31:0] i_window_start,
    input  logic [31:0] i_window_end,
    input  logic [31:0] i_duration,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [owjs_pkg::COUNT_OUT_W-1:0] o_best_count
);

    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    logic                  w_accept;
    owjs_pkg::t_job_ctl    w_ctl;
    logic [TIME_BITS-1:0]  w_ws;
    logic [TIME_BITS-1:0]  w_we;
    logic [TIME_BITS-1:0]  w_dur;
    logic [TIME_BITS-1:0]  w_fin  [MAX_JOBS];
    logic [MAX_JOBS-1:0]   w_grow;
    logic [CNT_W-1:0]      r_best;
    logic [CNT_W-1:0]      n_best;
    logic                  r_out_valid;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    generate
        if (TIME_BITS <= 32) begin : g_trunc
            assign w_ws  = i_window_start[TIME_BITS-1:0];
            assign w_we  = i_window_end[TIME_BITS-1:0];
            assign w_dur = i_duration[TIME_BITS-1:0];
        end else begin : g_ext
            assign w_ws  = {{(TIME_BITS-32){1'b0}}, i_window_start};
            assign w_we  = {{(TIME_BITS-32){1'b0}}, i_window_end};
            assign w_dur = {{(TIME_BITS-32){1'b0}}, i_duration};
        end
    endgenerate

    assign w_ctl.en     = w_accept;
    assign w_ctl.first  = i_first_job;
    assign w_ctl.active = (w_dur != '0);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_JOBS; gi++) begin : g_cell
            owjs_cell #(
                .TIME_BITS (TIME_BITS),
                .IS_HEAD   (gi == 0)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_prev_fin (w_fin[(gi == 0) ? 0 : gi - 1]),
                .i_ws       (w_ws),
                .i_we       (w_we),
                .i_dur      (w_dur),
                .o_fin      (w_fin[gi]),
                .o_grow     (w_grow[gi])
            );
        end
    endgenerate

    // Reachable counts form a prefix, so a job extends it by at most one.
    assign n_best = (i_first_job ? '0 : r_best) + CNT_W'(|w_grow);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_best      <= n_best;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    generate
        if (CNT_W >= owjs_pkg::COUNT_OUT_W) begin : g_out_trunc
            assign o_best_count = r_best[owjs_pkg::COUNT_OUT_W-1:0];
        end else begin : g_out_ext
            assign o_best_count = {{(owjs_pkg::COUNT_OUT_W-CNT_W){1'b0}}, r_best};
        end
    endgenerate

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted job produced no result beat");

    a_single_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_grow))
        else $error("more than one cell became reachable for one job");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best <= CNT_W'(MAX_JOBS))
        else $error("best count exceeds chain length");

    a_count_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_first_job) |=> (r_best >= $past(r_best)))
        else $error("best count dropped without a first job");

endmodule

// File: dv/tb_ordered_window_job_scheduler.sv
// ----------------------------------------------------------------------------
// tb_ordered_window_job_scheduler
// Self-checking bench for the ordered window job scheduler. A queue of jobs
// (directed corner cases, then random job chains and noise) feeds a clocked
// driver; a clocked monitor checks each reported count against a model of
// the finish-time table kept in the bench. Idle and stall rates change
// by phase, with one long output hold and full drains in between.
// ----------------------------------------------------------------------------
module tb_ordered_window_job_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_JOBS    = 64;
    localparam int HOLD_LEN    = 40;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic        first;
        logic [31:0] ws;
        logic [31:0] we;
        logic [31:0] dur;
    } t_job;

    typedef enum int { CHAIN_CLEAN, CHAIN_MESSY, CHAIN_BROKEN } t_chain_kind;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_first_job    = 1'b0;
    logic [31:0] i_window_start = '0;
    logic [31:0] i_window_end   = '0;
    logic [31:0] i_duration     = '0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [owjs_pkg::COUNT_OUT_W-1:0] o_best_count;

    ordered_window_job_scheduler DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_first_job    (i_first_job),
        .i_window_start (i_window_start),
        .i_window_end   (i_window_end),
        .i_duration     (i_duration),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_best_count   (o_best_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_job                             pending_jobs[$];
    t_job                             offered_job;
    logic [owjs_pkg::COUNT_OUT_W-1:0] expected_counts[$];
    logic [31:0]                      finish_by_count[MAX_JOBS];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_on      = 1'b0;
    logic hold_done    = 1'b0;
    int hold_cycles    = 0;

    int jobs_queued    = 0;
    int jobs_accepted  = 0;
    int counts_checked = 0;
    int blocked_beats  = 0;
    int peak_count     = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("ERROR @%0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
        error_count++;
    endtask

    // Applies one job to the finish-time table, returns the best reachable count.
    function automatic logic [owjs_pkg::COUNT_OUT_W-1:0] schedule_job(input t_job job);
        longint unsigned prev_fin;
        longint unsigned start_t;
        longint unsigned end_t;
        logic [owjs_pkg::COUNT_OUT_W-1:0] best;
        int c;
        best = '0;
        if (job.first) begin
            for (c = 0; c < MAX_JOBS; c++) finish_by_count[c] = '0;
        end
        if (job.dur != 0) begin
            // high to low so each count reads the table as it stood before this job
            for (c = MAX_JOBS; c >= 1; c--) begin
                prev_fin = (c == 1) ? 64'd0 : longint'(finish_by_count[c-2]);
                if (c == 1 || prev_fin != 0) begin
                    start_t = prev_fin + 1;
                    if (job.ws > start_t) start_t = job.ws;
                    end_t = start_t + job.dur - 1;
                    if (end_t <= job.we &&
                        (finish_by_count[c-1] == 0 || end_t < finish_by_count[c-1])) begin
                        finish_by_count[c-1] = end_t[31:0];
                    end
                end
            end
        end
        for (c = MAX_JOBS; c >= 1 && best == 0; c--) begin
            if (finish_by_count[c-1] != 0) best = 7'(c);
        end
        return best;
    endfunction

    task automatic push_job(input logic first, input longint unsigned ws,
                            input longint unsigned we, input longint unsigned dur);
        t_job job;
        job.first = first;
        job.ws    = 32'(ws);
        job.we    = 32'(we);
        job.dur   = 32'(dur);
        pending_jobs = {pending_jobs, job};
        jobs_queued++;
    endtask

    task automatic add_noise(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            push_job($urandom_range(7) == 0, $urandom, $urandom, $urandom);
        end
    endtask

    // A run of jobs marching forward in time, opened by a first_job beat.
    task automatic add_chain(input int len, input t_chain_kind kind, input int dscale);
        longint unsigned t;
        longint unsigned ws;
        longint unsigned we;
        longint unsigned dur;
        logic first;
        int k;
        t = $urandom_range(0, 500);
        if (kind != CHAIN_CLEAN && $urandom_range(7) == 0) begin
            t = 64'hFFFF_0000 + $urandom_range(0, 16'hFFFF);   // high time bits, may wrap
        end
        for (k = 0; k < len; k++) begin
            first = (k == 0);
            dur   = $urandom_range(1, dscale);
            ws    = t + $urandom_range(0, dscale);
            we    = ws + dur - 1 + $urandom_range(0, 3 * dscale);
            if (kind != CHAIN_CLEAN) begin
                if ($urandom_range(3) == 0 && t > dscale) ws = t - $urandom_range(1, dscale);
                if ($urandom_range(4) == 0) we = ws + dur - 1;
                if ($urandom_range(5) == 0 && ws + dur >= 2) we = ws + dur - 2;
            end
            if (kind == CHAIN_BROKEN) begin
                case ($urandom_range(5))
                    0: dur = 0;
                    1: ws = 0;
                    2: we = $urandom;
                    3: first = 1'b1;
                    default: ;
                endcase
            end
            push_job(first, ws, we, dur);
            t = ws + dur;
        end
    endtask

    task automatic add_random(input int n);
        int target;
        int r;
        int len;
        int dscale;
        target = jobs_queued + n;
        while (jobs_queued < target) begin
            r      = $urandom_range(99);
            len    = ($urandom_range(11) == 0) ? $urandom_range(66, 80) : $urandom_range(2, 20);
            case ($urandom_range(2))
                0: dscale = 2;
                1: dscale = 60;
                default: dscale = 100000;
            endcase
            if (r < 15) add_noise($urandom_range(1, 4));
            else if (r < 30) add_chain(len, CHAIN_BROKEN, dscale);
            else if (r < 60) add_chain(len, CHAIN_CLEAN, dscale);
            else add_chain(len, CHAIN_MESSY, dscale);
        end
    endtask

    task automatic drain();
        while (pending_jobs.size() != 0 || i_in_valid || expected_counts.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_stall) blocked_beats++;
            if (i_in_valid && !o_in_stall) begin
                expected_counts = {expected_counts, schedule_job(offered_job)};
                jobs_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_jobs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_job    = pending_jobs.pop_front();
                    i_first_job    <= offered_job.first;
                    i_window_start <= offered_job.ws;
                    i_window_end   <= offered_job.we;
                    i_duration     <= offered_job.dur;
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output back-pressure, with a long counted hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end else if (hold_on && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == HOLD_LEN - 1) hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (!hold_on) begin
                hold_done   <= 1'b0;
                hold_cycles <= 0;
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_counts.size() == 0) begin
                report_mismatch("unexpected best_count beat", -1, o_best_count);
            end else begin
                if (o_best_count !== expected_counts[0]) begin
                    report_mismatch("best_count", expected_counts[0], o_best_count);
                end
                if (expected_counts[0] > peak_count) peak_count = expected_counts[0];
                void'(expected_counts.pop_front());
                counts_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d counts outstanding",
                     cycle_count, expected_counts.size());
            $display("FAIL ordered_window_job_scheduler");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners
        push_job(1, 1, 1, 1);                                  // tightest window
        push_job(0, 0, 2, 1);                                  // zero window start
        push_job(0, 5, 100, 0);                                // zero duration
        push_job(0, 50, 40, 1);                                // start past window end
        push_job(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // end beyond 32 bits
        push_job(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);          // finish at max time
        push_job(0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_job(1, 0, 0, 1);                                  // clear, nothing fits
        push_job(1, 0, 0, 0);
        push_job(1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1);
        push_job(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);          // whole time range
        push_job(0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        push_job(0, 32'h5555_5555, 32'hFFFF_FFFF, 32'h5555_5555);
        push_job(0, 1, 2, 1);                                  // earlier finish replaces
        push_job(0, 3, 3, 1);
        push_job(0, 2, 3, 2);                                  // equal end, no update
        drain();

        // long output hold while jobs keep coming, so the input side backs up
        hold_on = 1'b1;
        add_random(30);
        while (!hold_done) @(negedge i_clk);
        hold_on = 1'b0;
        drain();   // sender waits for every count before going on

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            if (ph == 0) add_chain(72, CHAIN_CLEAN, 2);   // runs past MAX_JOBS
            add_random(100);
            while (pending_jobs.size() != 0) @(negedge i_clk);
        end
        drain();
        repeat (4) @(posedge i_clk);

        $display("Ran %0d jobs through %0d counts, peak count %0d, %0d stalled input beats",
                 jobs_accepted, counts_checked, peak_count, blocked_beats);
        if (error_count == 0) begin
            $display("PASS ordered_window_job_scheduler");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL ordered_window_job_scheduler");
        end
        $finish;
    end

endmodule
